// ===== rtl/stc_pkg.sv =====
// Shared types, codes and helper functions for the scalar token classifier.
package stc_pkg;

  // Number grammar phases
  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_SIGN   = 4'd1;
  localparam logic [3:0] PH_ZERO   = 4'd2;
  localparam logic [3:0] PH_INT    = 4'd3;
  localparam logic [3:0] PH_DOT    = 4'd4;
  localparam logic [3:0] PH_FRAC   = 4'd5;
  localparam logic [3:0] PH_EXP    = 4'd6;
  localparam logic [3:0] PH_EXPSGN = 4'd7;
  localparam logic [3:0] PH_EXPDIG = 4'd8;
  localparam logic [3:0] PH_ERR    = 4'd9;

  // Result classes
  localparam logic [2:0] CLS_STRING = 3'd0;
  localparam logic [2:0] CLS_NULL   = 3'd1;
  localparam logic [2:0] CLS_TRUE   = 3'd2;
  localparam logic [2:0] CLS_FALSE  = 3'd3;
  localparam logic [2:0] CLS_NUMBER = 3'd4;

  // Keyword mask bits
  localparam int KW_NULL  = 0;
  localparam int KW_TRUE  = 1;
  localparam int KW_FALSE = 2;

  localparam logic [2:0] KW_ALL     = 3'b111;
  localparam logic [2:0] POS_SAT    = 3'd6;
  localparam logic [2:0] LEN_NULL   = 3'd4;
  localparam logic [2:0] LEN_TRUE   = 3'd4;
  localparam logic [2:0] LEN_FALSE  = 3'd5;

  typedef struct packed {
    logic [7:0] ch;
    logic       quoted;
    logic       empty_req;
    logic       last;
  } item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [3:0] next_phase(input logic [3:0] ph, input logic [7:0] c);
    logic d;
    logic e;
    logic [3:0] nx;
    d = is_digit(c);
    e = (c == 8'h65) || (c == 8'h45);
    nx = PH_ERR;
    unique case (ph)
      PH_START: begin
        if (c == 8'h2d) nx = PH_SIGN;
        else if (c == 8'h30) nx = PH_ZERO;
        else if (d) nx = PH_INT;
      end
      PH_SIGN: begin
        if (c == 8'h30) nx = PH_ZERO;
        else if (d) nx = PH_INT;
      end
      PH_ZERO: begin
        if (c == 8'h2e) nx = PH_DOT;
        else if (e) nx = PH_EXP;
      end
      PH_INT: begin
        if (d) nx = PH_INT;
        else if (c == 8'h2e) nx = PH_DOT;
        else if (e) nx = PH_EXP;
      end
      PH_DOT: begin
        if (d) nx = PH_FRAC;
      end
      PH_FRAC: begin
        if (d) nx = PH_FRAC;
        else if (e) nx = PH_EXP;
      end
      PH_EXP: begin
        if ((c == 8'h2b) || (c == 8'h2d)) nx = PH_EXPSGN;
        else if (d) nx = PH_EXPDIG;
      end
      PH_EXPSGN, PH_EXPDIG: begin
        if (d) nx = PH_EXPDIG;
      end
      default: nx = PH_ERR;
    endcase
    return nx;
  endfunction

  function automatic logic phase_accepts(input logic [3:0] ph);
    return (ph == PH_ZERO) || (ph == PH_INT) || (ph == PH_FRAC) || (ph == PH_EXPDIG);
  endfunction

  // Which keywords have character c at position pos
  function automatic logic [2:0] kw_char_hit(input logic [2:0] pos, input logic [7:0] c);
    logic [2:0] hit;
    hit = 3'b000;
    unique case (pos)
      3'd0: begin
        hit[KW_NULL]  = (c == 8'h6e);
        hit[KW_TRUE]  = (c == 8'h74);
        hit[KW_FALSE] = (c == 8'h66);
      end
      3'd1: begin
        hit[KW_NULL]  = (c == 8'h75);
        hit[KW_TRUE]  = (c == 8'h72);
        hit[KW_FALSE] = (c == 8'h61);
      end
      3'd2: begin
        hit[KW_NULL]  = (c == 8'h6c);
        hit[KW_TRUE]  = (c == 8'h75);
        hit[KW_FALSE] = (c == 8'h6c);
      end
      3'd3: begin
        hit[KW_NULL]  = (c == 8'h6c);
        hit[KW_TRUE]  = (c == 8'h65);
        hit[KW_FALSE] = (c == 8'h73);
      end
      3'd4: begin
        hit[KW_FALSE] = (c == 8'h65);
      end
      default: hit = 3'b000;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/stc_in_stage.sv =====
// Input register stage: holds one accepted transaction until the core takes it.
module stc_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  stc_pkg::item_t in_item,
  input  logic          take,
  output logic          item_vld,
  output stc_pkg::item_t item
);
  import stc_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  logic  load;

  assign in_stall = vld_r && !take;
  assign load     = in_valid && !in_stall;
  assign vld_nxt  = load ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;
endmodule

// ===== rtl/stc_core.sv =====
// Token state (number phase, keyword mask, position) and class decision.
module stc_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_vld,
  input  stc_pkg::item_t item,
  input  logic           res_free,
  output logic           take,
  output logic           res_load,
  output logic [2:0]     res_class
);
  import stc_pkg::*;

  logic [3:0] phase_r;
  logic [3:0] phase_nxt;
  logic [2:0] alive_r;
  logic [2:0] alive_nxt;
  logic [2:0] pos_r;
  logic [2:0] pos_nxt;
  logic       ends;
  logic [2:0] cls;

  assign ends      = item.empty_req || item.last;
  assign take      = item_vld && (!ends || res_free);
  assign res_load  = take && ends;

  assign phase_nxt = next_phase(phase_r, item.ch);
  assign alive_nxt = alive_r & kw_char_hit(pos_r, item.ch);
  assign pos_nxt   = (pos_r < POS_SAT) ? pos_r + 3'd1 : POS_SAT;

  always_comb begin
    priority if (item.empty_req || item.quoted) begin
      cls = CLS_STRING;
    end else if (alive_nxt[KW_NULL] && (pos_nxt == LEN_NULL)) begin
      cls = CLS_NULL;
    end else if (alive_nxt[KW_TRUE] && (pos_nxt == LEN_TRUE)) begin
      cls = CLS_TRUE;
    end else if (alive_nxt[KW_FALSE] && (pos_nxt == LEN_FALSE)) begin
      cls = CLS_FALSE;
    end else if (phase_accepts(phase_nxt)) begin
      cls = CLS_NUMBER;
    end else begin
      cls = CLS_STRING;
    end
  end

  assign res_class = cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      alive_r <= KW_ALL;
      pos_r   <= 3'd0;
    end else if (take) begin
      // ending transaction returns the token state to its start
      if (ends) begin
        phase_r <= PH_START;
        alive_r <= KW_ALL;
        pos_r   <= 3'd0;
      end else begin
        phase_r <= phase_nxt;
        alive_r <= alive_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end
endmodule

// ===== rtl/stc_out_stage.sv =====
// Output register: holds one class result until the receiver takes it.
module stc_out_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_load,
  input  logic [2:0] res_class,
  output logic       res_free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_scalar_class
);
  logic       vld_r;
  logic       vld_nxt;
  logic [2:0] cls_r;

  assign res_free = !vld_r || !out_stall;
  assign vld_nxt  = res_load ? 1'b1 : (res_free ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      cls_r <= res_class;
    end
  end

  assign out_valid        = vld_r;
  assign out_scalar_class = cls_r;
endmodule

// ===== rtl/scalar_token_classifier.sv =====
// Top level of the scalar token classifier.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_stall, in_ch, in_quoted,      | input
//           | in_empty_req, in_last                      |
//   out     | out_valid, out_stall, out_scalar_class     | output
//
// One character per cycle while no ending transaction waits on a stalled output:
// an accepted transaction sits in the input register, from there it updates the
// token state and, when it ends a scalar, loads the class into the output register.
// Reset (rst_n low, synchronous) clears both stage valids and the token state.
// A stalled output only holds back ending transactions; others still advance.
module scalar_token_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_quoted,
  input  logic       in_empty_req,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_scalar_class
);
  import stc_pkg::*;

  item_t      in_item;
  item_t      item;
  logic       item_vld;
  logic       take;
  logic       res_load;
  logic       res_free;
  logic [2:0] res_class;

  assign in_item.ch        = in_ch;
  assign in_item.quoted    = in_quoted;
  assign in_item.empty_req = in_empty_req;
  assign in_item.last      = in_last;

  stc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  stc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .res_free  (res_free),
    .take      (take),
    .res_load  (res_load),
    .res_class (res_class)
  );

  stc_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_load         (res_load),
    .res_class        (res_class),
    .res_free         (res_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scalar_class (out_scalar_class)
  );
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the scalar token classifier: directed rows, then random tokens.
module testbench;
  import stc_pkg::*;

  localparam int DIR_ROWS    = 25;
  localparam int RAND_ITEMS  = 1400;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_TAIL  = 10;
  localparam int PRINT_LIMIT = 40;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_ch;
  logic       in_quoted;
  logic       in_empty_req;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_scalar_class;

  scalar_token_classifier dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_ch(in_ch),
    .in_quoted(in_quoted),
    .in_empty_req(in_empty_req),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_scalar_class(out_scalar_class)
  );

  typedef struct packed {
    logic [7:0] ch;
    logic       quoted;
    logic       empty_req;
    logic       last;
    logic       known;
    logic [2:0] cls;
  } dir_row_t;

  // indexed by KW_NULL, KW_TRUE, KW_FALSE
  string      kw_words [3] = '{"null", "true", "false"};
  logic [2:0] kw_cls [3]   = '{CLS_NULL, CLS_TRUE, CLS_FALSE};

  dir_row_t   dir_table [DIR_ROWS];
  logic [2:0] expected_class [$];
  logic [7:0] txt [$];

  // token state of the predictor
  logic [3:0] tok_phase;
  logic [2:0] tok_alive;
  logic [2:0] tok_pos;

  int errors;
  int sent;
  int results_seen;
  int class_count [5];
  int burst_left;
  int idle_cycles;
  int stall_left;
  int stall_mode;
  logic [2:0] want;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_LIMIT) $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic logic is_num_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // JSON number grammar, one character at a time
  function automatic logic [3:0] advance_number(input logic [3:0] ph, input logic [7:0] c);
    logic dig;
    logic expo;
    dig  = is_num_digit(c);
    expo = (c == "e") || (c == "E");
    case (ph)
      PH_START: begin
        if (c == "-") return PH_SIGN;
        if (c == "0") return PH_ZERO;
        return dig ? PH_INT : PH_ERR;
      end
      PH_SIGN: begin
        if (c == "0") return PH_ZERO;
        return dig ? PH_INT : PH_ERR;
      end
      PH_ZERO: begin
        if (c == ".") return PH_DOT;
        return expo ? PH_EXP : PH_ERR;
      end
      PH_INT: begin
        if (dig) return PH_INT;
        if (c == ".") return PH_DOT;
        return expo ? PH_EXP : PH_ERR;
      end
      PH_DOT: return dig ? PH_FRAC : PH_ERR;
      PH_FRAC: begin
        if (dig) return PH_FRAC;
        return expo ? PH_EXP : PH_ERR;
      end
      PH_EXP: begin
        if (c == "+" || c == "-") return PH_EXPSGN;
        return dig ? PH_EXPDIG : PH_ERR;
      end
      PH_EXPSGN, PH_EXPDIG: return dig ? PH_EXPDIG : PH_ERR;
      default: return PH_ERR;
    endcase
  endfunction

  task automatic clear_token();
    tok_phase = PH_START;
    tok_alive = KW_ALL;
    tok_pos   = 3'd0;
  endtask

  // Updates the token state for one accepted transaction; flags a result on the ending one.
  task automatic classify_byte(input item_t it, output logic produces, output logic [2:0] cls);
    logic [2:0] alive;
    logic       found;
    alive    = tok_alive;
    found    = 1'b0;
    produces = 1'b0;
    cls      = CLS_STRING;
    if (it.empty_req) begin
      produces = 1'b1;
      clear_token();
      return;
    end
    for (int k = 0; k < 3; k++) begin
      if (!(tok_pos < kw_words[k].len() && kw_words[k][tok_pos] == it.ch)) alive[k] = 1'b0;
    end
    tok_phase = advance_number(tok_phase, it.ch);
    tok_alive = alive;
    tok_pos   = (tok_pos < POS_SAT) ? tok_pos + 3'd1 : POS_SAT;
    if (!it.last) return;
    produces = 1'b1;
    if (!it.quoted) begin
      for (int k = 0; k < 3; k++) begin
        if (!found && tok_alive[k] && tok_pos == kw_words[k].len()) begin
          cls   = kw_cls[k];
          found = 1'b1;
        end
      end
      if (!found && (tok_phase == PH_ZERO || tok_phase == PH_INT ||
                     tok_phase == PH_FRAC || tok_phase == PH_EXPDIG)) begin
        cls = CLS_NUMBER;
      end
    end
    clear_token();
  endtask

  // Drives one transaction in sender bursts; a typed class overrides the prediction.
  task automatic send_item(input item_t it, input logic known, input logic [2:0] typed_cls);
    int         gap;
    logic       produces;
    logic [2:0] cls;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_ch        <= it.ch;
    in_quoted    <= it.quoted;
    in_empty_req <= it.empty_req;
    in_last      <= it.last;
    do @(posedge clk); while (in_stall);
    sent++;
    classify_byte(it, produces, cls);
    if (produces) expected_class.push_back(known ? typed_cls : cls);
  endtask

  task automatic emit_token(input logic qflag);
    item_t it;
    int    n;
    n = txt.size();
    if (n == 0) begin
      it.ch        = 8'($urandom);
      it.quoted    = 1'($urandom);
      it.empty_req = 1'b1;
      it.last      = 1'($urandom);
      send_item(it, 1'b0, CLS_STRING);
      return;
    end
    for (int i = 0; i < n; i++) begin
      // rare stray empty scalar in the middle of a token
      if ($urandom_range(0, 99) == 0) begin
        it.ch        = 8'($urandom);
        it.quoted    = 1'($urandom);
        it.empty_req = 1'b1;
        it.last      = 1'($urandom);
        send_item(it, 1'b0, CLS_STRING);
      end
      it.ch        = txt[i];
      it.empty_req = 1'b0;
      it.last      = (i == n - 1);
      it.quoted    = it.last ? qflag : 1'($urandom);
      send_item(it, 1'b0, CLS_STRING);
    end
  endtask

  task automatic push_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) txt.push_back(8'("0" + $urandom_range(0, 9)));
  endtask

  task automatic build_number(input int max_int);
    if ($urandom_range(0, 2) == 0) txt.push_back("-");
    if ($urandom_range(0, 3) == 0) begin
      txt.push_back("0");
    end else begin
      txt.push_back(8'("1" + $urandom_range(0, 8)));
      push_digits(0, max_int);
    end
    if ($urandom_range(0, 1) == 0) begin
      txt.push_back(".");
      push_digits(1, 4);
    end
    if ($urandom_range(0, 2) == 0) begin
      txt.push_back($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: txt.push_back("+");
        1: txt.push_back("-");
        default: ;
      endcase
      push_digits(1, 3);
    end
  endtask

  // damage a well-formed token: replace, drop or add one character
  task automatic mutate_token();
    int pos;
    pos = $urandom_range(0, txt.size() - 1);
    case ($urandom_range(0, 2))
      0: txt[pos] = 8'($urandom);
      1: if (txt.size() > 1) txt.delete(pos);
      default: txt.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'("0" + $urandom_range(0, 9)));
    endcase
  endtask

  task automatic build_keyword();
    string w;
    w = kw_words[$urandom_range(0, 2)];
    for (int j = 0; j < w.len(); j++) txt.push_back(w[j]);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: txt.delete(txt.size() - 1);
        1: txt.push_back(w[$urandom_range(0, w.len() - 1)]);
        default: txt[$urandom_range(0, w.len() - 1)] = 8'($urandom_range(8'h61, 8'h7a));
      endcase
    end
  endtask

  task automatic build_letters();
    string alpha;
    alpha = "nultrefasNE0-";
    repeat ($urandom_range(1, 8)) txt.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
  endtask

  // receiver: stall pattern switches between free, light and heavy stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      results_seen++;
      if (expected_class.size() == 0) begin
        report_mismatch($sformatf("result class %0d with nothing expected", out_scalar_class));
      end else begin
        want = expected_class.pop_front();
        class_count[want]++;
        if (out_scalar_class !== want)
          report_mismatch($sformatf("scalar_class got %0d expected %0d", out_scalar_class, want));
      end
    end
  end

  // watchdog: cycles in which neither channel completes a transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results pending",
                 IDLE_LIMIT, expected_class.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    item_t it;
    logic  paused;
    int    kind;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_ch        = 8'h00;
    in_quoted    = 1'b0;
    in_empty_req = 1'b0;
    in_last      = 1'b0;
    out_stall    = 1'b0;
    errors       = 0;
    sent         = 0;
    results_seen = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    stall_mode   = 0;
    paused       = 1'b0;
    foreach (class_count[i]) class_count[i] = 0;
    clear_token();

    dir_table = '{
      '{8'hff, 1'b1, 1'b1, 1'b0, 1'b1, CLS_STRING},  // empty scalar, other fields junk
      '{"n",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"u",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"l",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"l",   1'b0, 1'b0, 1'b1, 1'b1, CLS_NULL},
      '{"0",   1'b0, 1'b0, 1'b1, 1'b1, CLS_NUMBER},  // lone zero
      '{"-",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"0",   1'b0, 1'b0, 1'b1, 1'b1, CLS_NUMBER},  // minus zero
      '{"t",   1'b1, 1'b0, 1'b0, 1'b0, CLS_STRING},  // quoted only counts at the end
      '{"r",   1'b1, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"u",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"e",   1'b0, 1'b0, 1'b1, 1'b1, CLS_TRUE},
      '{"f",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"a",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"l",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"s",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"e",   1'b1, 1'b0, 1'b1, 1'b1, CLS_STRING},  // quoted keyword
      '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, CLS_STRING},
      '{8'hff, 1'b0, 1'b0, 1'b1, 1'b0, CLS_STRING},
      '{"1",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},  // six chars: position saturates
      '{".",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"5",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"e",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"+",   1'b0, 1'b0, 1'b0, 1'b0, CLS_STRING},
      '{"7",   1'b0, 1'b0, 1'b1, 1'b0, CLS_STRING}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[r]) begin
      it.ch        = dir_table[r].ch;
      it.quoted    = dir_table[r].quoted;
      it.empty_req = dir_table[r].empty_req;
      it.last      = dir_table[r].last;
      send_item(it, dir_table[r].known, dir_table[r].cls);
    end

    while (sent < DIR_ROWS + RAND_ITEMS) begin
      // halfway through, hold off until every pending class is out
      if (!paused && sent > DIR_ROWS + RAND_ITEMS / 2) begin
        paused = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_class.size() != 0) @(posedge clk);
        burst_left = 0;
      end
      txt.delete();
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        build_number(4);
        if ($urandom_range(0, 4) == 0) mutate_token();
        emit_token(1'b0);
      end else if (kind < 55) begin
        build_keyword();
        emit_token(1'b0);
      end else if (kind < 65) begin
        build_letters();
        emit_token(1'b0);
      end else if (kind < 75) begin
        if ($urandom_range(0, 1)) build_number(4);
        else build_keyword();
        emit_token(1'b1);
      end else if (kind < 82) begin
        emit_token(1'($urandom));
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 10)) txt.push_back(8'($urandom));
        emit_token(1'($urandom));
      end else begin
        build_number(14);
        emit_token(1'b0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_class.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("%0d transactions in, %0d classes checked: string %0d null %0d true %0d",
             sent, results_seen, class_count[CLS_STRING], class_count[CLS_NULL],
             class_count[CLS_TRUE]);
    $display("false %0d number %0d, %0d mismatches", class_count[CLS_FALSE],
             class_count[CLS_NUMBER], errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
